FILE: sv/fm_voice_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// fm voice allocator assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FM_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define FM_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FVA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FVA_ASSERT_IMPL(lbl, ante, cons, msg)

`define FVA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/fva_pkg.sv
// ----------------------------------------------------------------------------
// fva_pkg
// shared types and constants of the fm voice allocator
// ----------------------------------------------------------------------------
package fva_pkg;

  localparam int unsigned ChanW     = 4;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned VoiceIdxW = 5;
  localparam int unsigned Vel10W    = 11;
  localparam int unsigned VelWeight = 10;

  // x / 1000 == (x * DivMagic) >> DivShift for every 32-bit x
  localparam int unsigned DivMagicW = 29;
  localparam logic [DivMagicW-1:0] DivMagic = 29'd274877907;
  localparam int unsigned DivShift  = 38;
  localparam int unsigned ProdW     = TimeW + DivMagicW;
  localparam int unsigned PrioW     = ProdW - DivShift;

  localparam logic [ChanW-1:0] ProtChanReset = 4'd9;

  localparam logic ReqNoteOn  = 1'b0;
  localparam logic ReqNoteOff = 1'b1;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NoteW-1:0] note_t;
  typedef logic [VelW-1:0]  vel_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [PrioW-1:0] prio_t;

  typedef struct packed {
    logic  req_type;
    chan_t chan_num;
    note_t note_number;
    vel_t  note_velocity;
    time_t time_ms;
  } req_t;

  typedef struct packed {
    logic [VoiceIdxW-1:0] voice_index;
    logic                 found;
    logic                 stolen;
    note_t                prev_note;
  } res_t;

  typedef struct packed {
    chan_t channel;
    note_t note;
    vel_t  velocity;
    time_t onset_ms;
  } entry_t;

  typedef struct packed {
    logic  valid;
    logic  hit;
    logic  prot;
    note_t note;
    prio_t prio;
  } scan_t;

endpackage

FILE: sv/fm_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// fm_voice_allocator_unit
// synthesiser voice allocation with stealing over a voice table memory
//
// channel  | ports                        | handshake
// request  | start_i, req_i, busy_o       | taken when start_i high, busy_o low
// result   | res_valid_o, res_o           | one-cycle strobe, no back-pressure
// config   | cfg_we_i, cfg_wdata_i        | written on any edge with cfg_we_i
//
// note on with a free voice: strobe in the cycle after the accepting one
// otherwise the table is scanned one voice per cycle through the memory read
// port and a two-stage priority pipe; the result is registered from StFinish
// busy_o is low again in the strobe cycle; reset leaves every voice free and
// the protected channel at 9
// ----------------------------------------------------------------------------
`include "fm_voice_allocator_unit_defines.svh"

module fm_voice_allocator_unit #(
  parameter int unsigned NUM_VOICES = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fva_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output fva_pkg::res_t   res_o,
  input  logic            cfg_we_i,
  input  fva_pkg::chan_t  cfg_wdata_i
);
  import fva_pkg::*;

  localparam int unsigned IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VOICES - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StWait   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [IdxW-1:0]       rd_cnt_q, rd_cnt_d;
  logic                  rv_q;
  logic [IdxW-1:0]       ridx_q;
  logic [NUM_VOICES-1:0] active_q, active_d;
  chan_t                 prot_q;
  req_t                  req_q;

  logic                  match_hit_q, match_hit_d;
  logic [IdxW-1:0]       match_idx_q, match_idx_d;
  note_t                 match_note_q, match_note_d;
  logic                  have_best_q, have_best_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  prio_t                 best_prio_q, best_prio_d;
  note_t                 best_note_q, best_note_d;
  note_t                 v0_note_q, v0_note_d;

  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;

  logic                  accept;
  logic                  any_free;
  logic [IdxW-1:0]       free_idx;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  entry_t                mem_wdata;
  entry_t                mem_rdata;
  scan_t                 scan;
  logic [IdxW-1:0]       scan_idx;
  logic [IdxW-1:0]       pick_idx;
  note_t                 pick_note;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  fva_voice_mem #(
    .Depth (NUM_VOICES),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == StScan),
    .raddr_i (rd_cnt_q),
    .rdata_o (mem_rdata)
  );

  fva_prio_pipe #(
    .IdxW (IdxW)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rv_q),
    .in_idx_i    (ridx_q),
    .entry_i     (mem_rdata),
    .now_i       (req_q.time_ms),
    .chan_i      (req_q.chan_num),
    .note_i      (req_q.note_number),
    .prot_chan_i (prot_q),
    .scan_o      (scan),
    .idx_o       (scan_idx)
  );

  always_comb begin
    if (match_hit_q) begin
      pick_idx  = match_idx_q;
      pick_note = match_note_q;
    end else if (have_best_q) begin
      pick_idx  = best_idx_q;
      pick_note = best_note_q;
    end else begin
      pick_idx  = '0;
      pick_note = v0_note_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    active_d     = active_q;
    match_hit_d  = match_hit_q;
    match_idx_d  = match_idx_q;
    match_note_d = match_note_q;
    have_best_d  = have_best_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_note_d  = best_note_q;
    v0_note_d    = v0_note_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = free_idx;
    mem_wdata.channel  = req_i.chan_num;
    mem_wdata.note     = req_i.note_number;
    mem_wdata.velocity = req_i.note_velocity;
    mem_wdata.onset_ms = req_i.time_ms;

    if (scan.valid && (state_q == StScan || state_q == StWait)) begin
      if (scan_idx == '0) begin
        v0_note_d = scan.note;
      end
      if (active_q[scan_idx] && scan.hit && !match_hit_q) begin
        match_hit_d  = 1'b1;
        match_idx_d  = scan_idx;
        match_note_d = scan.note;
      end
      if (!scan.prot && (!have_best_q || scan.prio < best_prio_q)) begin
        have_best_d = 1'b1;
        best_idx_d  = scan_idx;
        best_prio_d = scan.prio;
        best_note_d = scan.note;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.req_type == ReqNoteOn && any_free) begin
            mem_we                = 1'b1;
            active_d[free_idx]    = 1'b1;
            res_valid_d           = 1'b1;
            res_d.voice_index     = VoiceIdxW'(free_idx);
            res_d.found           = 1'b1;
            res_d.stolen          = 1'b0;
            res_d.prev_note       = '0;
          end else begin
            state_d     = StScan;
            rd_cnt_d    = '0;
            match_hit_d = 1'b0;
            have_best_d = 1'b0;
          end
        end
      end
      StScan: begin
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q == LastIdx) begin
          rd_cnt_d = '0;
          state_d  = StWait;
        end
      end
      StWait: begin
        if (scan.valid && scan_idx == LastIdx) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        state_d     = StIdle;
        res_valid_d = 1'b1;
        mem_wdata.channel  = req_q.chan_num;
        mem_wdata.note     = req_q.note_number;
        mem_wdata.velocity = req_q.note_velocity;
        mem_wdata.onset_ms = req_q.time_ms;
        if (req_q.req_type == ReqNoteOn) begin
          mem_we            = 1'b1;
          mem_waddr         = pick_idx;
          active_d[pick_idx] = 1'b1;
          res_d.voice_index = VoiceIdxW'(pick_idx);
          res_d.found       = 1'b1;
          res_d.stolen      = 1'b1;
          res_d.prev_note   = pick_note;
        end else begin
          res_d.stolen    = 1'b0;
          res_d.prev_note = '0;
          if (match_hit_q) begin
            active_d[match_idx_q] = 1'b0;
            res_d.voice_index     = VoiceIdxW'(match_idx_q);
            res_d.found           = 1'b1;
          end else begin
            res_d.voice_index = '0;
            res_d.found       = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_cnt_q    <= '0;
      rv_q        <= 1'b0;
      active_q    <= '0;
      prot_q      <= ProtChanReset;
      match_hit_q <= 1'b0;
      have_best_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      rv_q        <= (state_q == StScan);
      active_q    <= active_d;
      match_hit_q <= match_hit_d;
      have_best_q <= have_best_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        prot_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= rd_cnt_q;
    match_idx_q  <= match_idx_d;
    match_note_q <= match_note_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_note_q  <= best_note_d;
    v0_note_q    <= v0_note_d;
    res_q        <= res_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `FVA_ASSERT_NEXT(a_finish_strobe, state_q == StFinish, res_valid_o && !busy_o, "finish without result word")
  `FVA_ASSERT_NEXT(a_fast_path, accept && req_i.req_type == ReqNoteOn && any_free, res_valid_o && !res_o.stolen && !busy_o, "free voice not taken at once")
  `FVA_ASSERT_IMPL(a_stolen_found, res_valid_o && res_o.stolen, res_o.found, "stolen voice without found")
  `FVA_ASSERT_IMPL(a_scan_range, state_q == StScan, rd_cnt_q <= LastIdx, "read counter past last voice")

endmodule

FILE: sv/fva_voice_mem.sv
// ----------------------------------------------------------------------------
// fva_voice_mem
// voice table, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module fva_voice_mem #(
  parameter int unsigned Depth = 18,
  parameter int unsigned IdxW  = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  fva_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [IdxW-1:0]  raddr_i,
  output fva_pkg::entry_t  rdata_o
);
  import fva_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/fva_prio_pipe.sv
// ----------------------------------------------------------------------------
// fva_prio_pipe
// per-voice match and steal priority: age, divide by 1000, weighted velocity
// ----------------------------------------------------------------------------
module fva_prio_pipe #(
  parameter int unsigned IdxW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [IdxW-1:0]   in_idx_i,
  input  fva_pkg::entry_t   entry_i,
  input  fva_pkg::time_t    now_i,
  input  fva_pkg::chan_t    chan_i,
  input  fva_pkg::note_t    note_i,
  input  fva_pkg::chan_t    prot_chan_i,
  output fva_pkg::scan_t    scan_o,
  output logic [IdxW-1:0]   idx_o
);
  import fva_pkg::*;

  logic              s1_valid_q, s2_valid_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q;
  time_t             s1_diff_q;
  logic [Vel10W-1:0] s1_vel10_q, s2_vel10_q;
  logic              s1_hit_q, s2_hit_q;
  logic              s1_prot_q, s2_prot_q;
  note_t             s1_note_q, s2_note_q;
  prio_t             s2_quot_q;
  logic [ProdW-1:0]  prod;

  assign prod = ProdW'(s1_diff_q) * ProdW'(DivMagic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= in_idx_i;
    s1_diff_q  <= now_i - entry_i.onset_ms;
    s1_vel10_q <= Vel10W'(entry_i.velocity) * Vel10W'(VelWeight);
    s1_hit_q   <= (entry_i.channel == chan_i) && (entry_i.note == note_i);
    s1_prot_q  <= (entry_i.channel == prot_chan_i);
    s1_note_q  <= entry_i.note;

    s2_idx_q   <= s1_idx_q;
    s2_quot_q  <= prod[ProdW-1:DivShift];
    s2_vel10_q <= s1_vel10_q;
    s2_hit_q   <= s1_hit_q;
    s2_prot_q  <= s1_prot_q;
    s2_note_q  <= s1_note_q;
  end

  always_comb begin
    scan_o.valid = s2_valid_q;
    scan_o.hit   = s2_hit_q;
    scan_o.prot  = s2_prot_q;
    scan_o.note  = s2_note_q;
    scan_o.prio  = PrioW'(s2_vel10_q) + s2_quot_q;
  end

  assign idx_o = s2_idx_q;

endmodule

FILE: verif/tb_fm_voice_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_voice_allocator_unit
// self-checking bench for the voice allocator: a directed pass fills the
// voice table and walks through retrigger, stealing with ties and a skipped
// protected voice, and matched and unmatched releases; random phases then run
// mixed note traffic under several protected channel settings, including one
// where every voice sits on the protected channel. A behavioural copy of the
// voice table predicts each result word, and a monitor checks every strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fm_voice_allocator_unit;
  import fva_pkg::*;

  localparam int unsigned NumVoices   = 18;
  localparam int unsigned MsPerSec    = 1000;
  localparam int unsigned DrainCycles = NumVoices + 8;
  localparam int unsigned CycleLimit  = 500000;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  res_valid_o;
  res_t  res_o;
  logic  cfg_we_i;
  chan_t cfg_wdata_i;

  // predicted voice table
  logic  v_on    [NumVoices];
  chan_t v_chan  [NumVoices];
  note_t v_note  [NumVoices];
  vel_t  v_vel   [NumVoices];
  time_t v_start [NumVoices];
  chan_t prot_chan;

  res_t        voice_results_q[$];
  time_t       now_ms;
  bit          gaps_on;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned cycle_count;
  int unsigned n_on, n_off, n_free, n_retrig, n_steal, n_all_prot, n_release, n_unmatched;

  fm_voice_allocator_unit #(
    .NUM_VOICES(NumVoices)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               voice_results_q.size());
      $display("tb_fm_voice_allocator_unit failed");
      $finish;
    end
  end

  function automatic req_t build_word(input logic kind, input chan_t ch, input note_t nt,
                                      input vel_t vel, input time_t t);
    req_t word;
    word.req_type      = kind;
    word.chan_num      = ch;
    word.note_number   = nt;
    word.note_velocity = vel;
    word.time_ms       = t;
    return word;
  endfunction

  function automatic res_t allocate_voice(input req_t word);
    res_t        res;
    int unsigned pick;
    int unsigned i;
    logic [31:0] prio;
    logic [31:0] best_prio;
    bit          have;
    res = '0;
    if (word.req_type == ReqNoteOn) begin
      n_on++;
      pick = NumVoices;
      for (i = 0; i < NumVoices; i++)
        if (pick == NumVoices && !v_on[i]) pick = i;
      if (pick != NumVoices) n_free++;
      if (pick == NumVoices) begin
        for (i = 0; i < NumVoices; i++)
          if (pick == NumVoices && v_chan[i] == word.chan_num &&
              v_note[i] == word.note_number) pick = i;
        if (pick != NumVoices) n_retrig++;
      end
      if (pick == NumVoices) begin
        n_steal++;
        pick      = 0;
        have      = 1'b0;
        best_prio = '0;
        for (i = 0; i < NumVoices; i++) begin
          if (v_chan[i] != prot_chan) begin
            prio = 32'(v_vel[i]) * VelWeight + (word.time_ms - v_start[i]) / MsPerSec;
            if (!have || prio < best_prio) begin
              have      = 1'b1;
              best_prio = prio;
              pick      = i;
            end
          end
        end
        if (!have) n_all_prot++;
      end
      if (v_on[pick]) begin
        res.stolen    = 1'b1;
        res.prev_note = v_note[pick];
      end
      v_on[pick]        = 1'b1;
      v_chan[pick]      = word.chan_num;
      v_note[pick]      = word.note_number;
      v_vel[pick]       = word.note_velocity;
      v_start[pick]     = word.time_ms;
      res.voice_index   = pick[VoiceIdxW-1:0];
      res.found         = 1'b1;
    end else begin
      n_off++;
      pick = NumVoices;
      for (i = 0; i < NumVoices; i++)
        if (pick == NumVoices && v_on[i] && v_chan[i] == word.chan_num &&
            v_note[i] == word.note_number) pick = i;
      if (pick != NumVoices) begin
        n_release++;
        v_on[pick]      = 1'b0;
        res.voice_index = pick[VoiceIdxW-1:0];
        res.found       = 1'b1;
      end else begin
        n_unmatched++;
      end
    end
    return res;
  endfunction

  function automatic req_t random_word(input int unsigned off_pct);
    req_t        word;
    int unsigned pick;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) now_ms = $urandom;
    else if (sel > 2) now_ms = now_ms + $urandom_range(1, 5000);
    word.time_ms       = now_ms;
    word.note_velocity = ($urandom_range(0, 3) == 0) ?
                         ($urandom_range(0, 1) ? 7'd127 : 7'd0) : vel_t'($urandom);
    sel = $urandom_range(0, 7);
    word.chan_num     = (sel == 0) ? prot_chan :
                        (sel == 1) ? chan_t'($urandom) : chan_t'($urandom_range(0, 3));
    word.note_number  = ($urandom_range(0, 3) == 0) ? note_t'($urandom) :
                        note_t'($urandom_range(60, 71));
    pick = $urandom_range(0, NumVoices - 1);
    if ($urandom_range(0, 99) < off_pct) begin
      word.req_type = ReqNoteOff;
      if ($urandom_range(0, 3) != 0 && v_on[pick]) begin
        word.chan_num    = v_chan[pick];
        word.note_number = v_note[pick];
      end
    end else begin
      word.req_type = ReqNoteOn;
      if ($urandom_range(0, 7) == 0 && v_on[pick]) begin
        word.chan_num    = v_chan[pick];
        word.note_number = v_note[pick];
      end
    end
    return word;
  endfunction

  task automatic send_word(input req_t word);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= word;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    voice_results_q.push_back(allocate_voice(word));
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (voice_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_protected(input chan_t ch);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ch;
    @(posedge clk_i);
    prot_chan = ch;
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t exp_res;
    bit   bad;
    if (rst_ni && res_valid_o) begin
      if (voice_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: idx %0d found %0b stolen %0b prev %0d",
                   res_o.voice_index, res_o.found, res_o.stolen, res_o.prev_note);
      end else begin
        exp_res = voice_results_q.pop_front();
        checked++;
        bad = 1'b0;
        if (res_o.voice_index !== exp_res.voice_index) bad = 1'b1;
        if (res_o.found !== exp_res.found) bad = 1'b1;
        if (res_o.stolen !== exp_res.stolen) bad = 1'b1;
        if (res_o.prev_note !== exp_res.prev_note) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected idx %0d found %0b stolen %0b prev %0d, got idx %0d found %0b stolen %0b prev %0d",
                     checked, exp_res.voice_index, exp_res.found, exp_res.stolen,
                     exp_res.prev_note, res_o.voice_index, res_o.found, res_o.stolen,
                     res_o.prev_note);
        end
      end
    end
  end

  task automatic test_directed_allocation();
    int    i;
    vel_t  vel;
    note_t nt;
    time_t t0;
    for (i = 0; i < NumVoices; i++) begin
      vel = (i == 5 || i == 9 || i == 11) ? 7'd0 : vel_t'(127 - i);
      nt  = (i == NumVoices - 1) ? 7'd127 : note_t'(i * 7);
      t0  = (i == NumVoices - 1) ? 32'hFFFF_FFFF : 32'hFFFF_FC18;
      send_word(build_word(ReqNoteOn, chan_t'(i), nt, vel, t0));
    end
    // retrigger, then two steals with a tie and the protected voice skipped
    send_word(build_word(ReqNoteOn, 4'd3, 7'd21, 7'd64, 32'h0000_0BB8));
    send_word(build_word(ReqNoteOn, 4'd14, 7'd100, 7'd127, 32'h0000_0BB8));
    send_word(build_word(ReqNoteOn, 4'd14, 7'd101, 7'd1, 32'h0000_0BB8));
    send_word(build_word(ReqNoteOff, 4'd1, 7'd127, 7'd127, 32'h0000_0BB9));
    send_word(build_word(ReqNoteOff, 4'd1, 7'd127, 7'd0, 32'h0000_0BB9));
    send_word(build_word(ReqNoteOn, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
    send_word(build_word(ReqNoteOff, 4'd0, 7'd0, 7'd0, 32'h0000_0000));
  endtask

  task automatic test_random_traffic(input int unsigned words, input int unsigned off_pct);
    int unsigned i;
    for (i = 0; i < words; i++) send_word(random_word(off_pct));
  endtask

  task automatic test_all_protected(input chan_t ch);
    int    i;
    chan_t wch;
    for (i = 0; i < NumVoices; i++)
      if (v_on[i]) send_word(build_word(ReqNoteOff, v_chan[i], v_note[i], vel_t'($urandom), now_ms));
    for (i = 0; i < NumVoices + 20; i++) begin
      now_ms = now_ms + $urandom_range(0, 3000);
      wch = (i >= NumVoices && $urandom_range(0, 4) == 0) ? chan_t'($urandom) : ch;
      send_word(build_word(ReqNoteOn, wch, note_t'($urandom), vel_t'($urandom), now_ms));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    prot_chan   = ProtChanReset;
    now_ms      = $urandom;
    gaps_on     = 1'b1;
    for (int i = 0; i < NumVoices; i++) begin
      v_on[i]    = 1'b0;
      v_chan[i]  = '0;
      v_note[i]  = '0;
      v_vel[i]   = '0;
      v_start[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_allocation();
    wait_drained();
    write_protected(4'd0);
    test_random_traffic(420, 35);
    wait_drained();
    write_protected(4'd15);
    test_all_protected(4'd15);
    wait_drained();
    write_protected(4'd5);
    test_random_traffic(420, 50);
    wait_drained();
    write_protected(chan_t'($urandom));
    test_random_traffic(420, 30);
    wait_drained();
    write_protected(4'd15);
    gaps_on = 1'b0;
    test_random_traffic(420, 40);
    wait_drained();

    mismatches += voice_results_q.size();
    $display("covered %0d note-on and %0d note-off words in %0d cycles, %0d checked",
             n_on, n_off, cycle_count, checked);
    $display("allocations: %0d free, %0d retrigger, %0d stolen (%0d all protected); releases: %0d matched, %0d unmatched",
             n_free, n_retrig, n_steal, n_all_prot, n_release, n_unmatched);
    if (mismatches == 0) begin
      $display("tb_fm_voice_allocator_unit passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_fm_voice_allocator_unit failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/fva_pkg.sv
sv/fva_voice_mem.sv
sv/fva_prio_pipe.sv
sv/fm_voice_allocator_unit.sv
verif/tb_fm_voice_allocator_unit.sv
